[rtl/core/efd_pkg.sv]
// Shared types and constants for the escaped frame deframer.
`default_nettype none
package efd_pkg;

    localparam logic [7:0] HEAD_BYTE           = 8'hFE;
    localparam logic [7:0] TAIL_BYTE           = 8'hFF;
    localparam logic [7:0] ESC_FF_CODE         = 8'hFD;
    localparam logic [7:0] ESC_FE_CODE         = 8'hFC;
    localparam logic [7:0] HEADER_OVERHEAD     = 8'd4;
    localparam logic [7:0] MAX_FRAME_LEN_RESET = 8'd65;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_DONE   = 2'd1,
        KIND_LONG   = 2'd2,
        KIND_BADESC = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [7:0]  sender_port;
        logic [7:0]  target_port;
        logic [15:0] node_address;
        logic [7:0]  declared_length;
    } t_result;

endpackage
`default_nettype wire

[rtl/core/escaped_frame_deframer_core.sv]
// Escaped frame deframer: head hunt, header capture, payload unescape, abort checks.
//
// Usage
//   Input channel: raw received bytes on i_rx_byte, handshake i_in_valid / o_in_ready.
//   A word is taken at a rising edge with both high; one word per cycle is sustained while o_in_ready stays high.
//   Output channel: one result word (kind, decoded byte, index, header fields) on
//   o_out_valid / i_out_ready. Each result is registered (output or skid register).
//   Many input words (idle noise, header bytes, escape lead-ins) give none.
//   Throughput is one input word per cycle, as the state machine steps once per word;
//   the only limit is the output side taking its results.
//   Stall: the output register is backed by a one-deep skid register, so an input
//   word is still taken while a result waits. Only when both are full does
//   o_in_ready drop, and it rises again when the skid word moves on as the receiver takes a word.
//   Configuration: i_cfg_wr_en / i_cfg_wr_data write the raw frame limit at once,
//   and are meant to be used only while the block is idle.
//   Reset (synchronous, active low): frame state idle and hunting for the head,
//   counters and header fields zero, limit back to 65, both output stages empty.
//   No clearing pass is needed; the block is ready in the first cycle after reset.
`default_nettype none
module escaped_frame_deframer_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_wr_en,
    input  wire logic [7:0]  i_cfg_wr_data,
    // input channel
    input  wire logic        i_in_valid,
    output      logic        o_in_ready,
    input  wire logic [7:0]  i_rx_byte,
    // output channel
    output      logic        o_out_valid,
    input  wire logic        i_out_ready,
    output      efd_pkg::t_kind o_kind,
    output      logic [7:0]  o_payload_byte,
    output      logic [7:0]  o_payload_index,
    output      logic [7:0]  o_sender_port,
    output      logic [7:0]  o_target_port,
    output      logic [15:0] o_node_address,
    output      logic [7:0]  o_declared_length
);
    import efd_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_LEN  = 3'd1,
        PH_SRC  = 3'd2,
        PH_DST  = 3'd3,
        PH_ADLO = 3'd4,
        PH_ADHI = 3'd5,
        PH_DATA = 3'd6,
        PH_ESC  = 3'd7
    } t_phase;

    // frame state
    t_phase      r_phase,         n_phase;
    logic [7:0]  r_raw_count,     n_raw_count;
    logic [7:0]  r_decoded_count, n_decoded_count;
    logic [7:0]  r_stated_length, n_stated_length;
    logic [7:0]  r_src_port,      n_src_port;
    logic [7:0]  r_dst_port,      n_dst_port;
    logic [15:0] r_address,       n_address;
    logic [7:0]  r_max_frame_len;

    // output register and skid stage
    logic        r_o_valid;
    t_result     r_o_data;
    logic        r_s_valid;
    t_result     r_s_data;

    logic        in_acc;
    logic        out_free;
    logic        res_valid;
    t_result     res;

    assign o_in_ready = !r_s_valid;
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_o_valid || i_out_ready;

    // one step of the frame state machine for the byte on the input port
    always_comb begin
        n_phase         = r_phase;
        n_raw_count     = r_raw_count;
        n_decoded_count = r_decoded_count;
        n_stated_length = r_stated_length;
        n_src_port      = r_src_port;
        n_dst_port      = r_dst_port;
        n_address       = r_address;
        res_valid       = 1'b0;
        res.kind            = KIND_DATA;
        res.payload_byte    = 8'd0;
        res.payload_index   = r_decoded_count;
        res.sender_port     = r_src_port;
        res.target_port     = r_dst_port;
        res.node_address    = r_address;
        res.declared_length = r_stated_length;

        if (r_phase == PH_IDLE) begin
            // hunt for the head; everything else is noise
            if (i_rx_byte == HEAD_BYTE) begin
                n_phase         = PH_LEN;
                n_raw_count     = 8'd1;
                n_decoded_count = 8'd0;
                n_stated_length = 8'd0;
                n_src_port      = 8'd0;
                n_dst_port      = 8'd0;
                n_address       = 16'd0;
            end
        end else if (r_raw_count >= r_max_frame_len) begin
            // limit reached: abort before looking at the byte at all
            res_valid   = 1'b1;
            res.kind    = KIND_LONG;
            n_phase     = PH_IDLE;
            n_raw_count = 8'd0;
        end else begin
            n_raw_count = r_raw_count + 8'd1;
            case (r_phase)
                PH_LEN: begin
                    n_stated_length = (i_rx_byte >= HEADER_OVERHEAD) ?
                                      (i_rx_byte - HEADER_OVERHEAD) : 8'd0;
                    n_phase = PH_SRC;
                end
                PH_SRC: begin
                    n_src_port = i_rx_byte;
                    n_phase    = PH_DST;
                end
                PH_DST: begin
                    n_dst_port = i_rx_byte;
                    n_phase    = PH_ADLO;
                end
                PH_ADLO: begin
                    n_address = {8'd0, i_rx_byte};
                    n_phase   = PH_ADHI;
                end
                PH_ADHI: begin
                    n_address = {i_rx_byte, r_address[7:0]};
                    n_phase   = PH_DATA;
                end
                PH_DATA: begin
                    if (i_rx_byte == TAIL_BYTE) begin
                        res_valid   = 1'b1;
                        res.kind    = KIND_DONE;
                        n_phase     = PH_IDLE;
                        n_raw_count = 8'd0;
                    end else if (i_rx_byte == HEAD_BYTE) begin
                        n_phase = PH_ESC;
                    end else begin
                        res_valid        = 1'b1;
                        res.payload_byte = i_rx_byte;
                        n_decoded_count  = r_decoded_count + 8'd1;
                    end
                end
                PH_ESC: begin
                    if (i_rx_byte == ESC_FF_CODE || i_rx_byte == ESC_FE_CODE) begin
                        res_valid        = 1'b1;
                        res.payload_byte = (i_rx_byte == ESC_FF_CODE) ?
                                           TAIL_BYTE : HEAD_BYTE;
                        n_decoded_count  = r_decoded_count + 8'd1;
                        n_phase          = PH_DATA;
                    end else begin
                        res_valid   = 1'b1;
                        res.kind    = KIND_BADESC;
                        n_phase     = PH_IDLE;
                        n_raw_count = 8'd0;
                    end
                end
                default: begin
                    n_phase     = PH_IDLE;
                    n_raw_count = 8'd0;
                end
            endcase
        end
    end

    // frame state and limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_raw_count     <= 8'd0;
            r_decoded_count <= 8'd0;
            r_stated_length <= 8'd0;
            r_src_port      <= 8'd0;
            r_dst_port      <= 8'd0;
            r_address       <= 16'd0;
            r_max_frame_len <= MAX_FRAME_LEN_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_frame_len <= i_cfg_wr_data;
            end
            if (in_acc) begin
                r_phase         <= n_phase;
                r_raw_count     <= n_raw_count;
                r_decoded_count <= n_decoded_count;
                r_stated_length <= n_stated_length;
                r_src_port      <= n_src_port;
                r_dst_port      <= n_dst_port;
                r_address       <= n_address;
            end
        end
    end

    // output register with skid: skid drains first, new words go to the skid on a stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else if (out_free) begin
            if (r_s_valid) begin
                r_o_valid <= 1'b1;
                r_s_valid <= 1'b0;
            end else begin
                r_o_valid <= in_acc && res_valid;
            end
        end else if (in_acc && res_valid) begin
            r_s_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_s_valid) begin
                r_o_data <= r_s_data;
            end else if (in_acc && res_valid) begin
                r_o_data <= res;
            end
        end else if (in_acc && res_valid) begin
            r_s_data <= res;
        end
    end

    assign o_out_valid       = r_o_valid;
    assign o_kind            = r_o_data.kind;
    assign o_payload_byte    = r_o_data.payload_byte;
    assign o_payload_index   = r_o_data.payload_index;
    assign o_sender_port     = r_o_data.sender_port;
    assign o_target_port     = r_o_data.target_port;
    assign o_node_address    = r_o_data.node_address;
    assign o_declared_length = r_o_data.declared_length;

    // skid only ever holds a word behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_valid |-> r_o_valid)
        else $error("skid word without output word");

    // a result produced while the output is stalled lands in the skid
    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && res_valid && !out_free) |=> r_s_valid)
        else $error("stalled result lost");

    // raw count is zero exactly when hunting for a head
    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) == (r_raw_count == 8'd0))
        else $error("raw count out of step with phase");

    // a frame end always returns to head hunting
    a_end_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && res_valid && res.kind != KIND_DATA) |=> (r_phase == PH_IDLE))
        else $error("frame end did not return to idle");

endmodule
`default_nettype wire
